[design/signed_binary_to_decimal_ascii_unit_macros.svh]
// Assertion helpers for the decimal ASCII converter.
// Each helper takes a label, the clock, the reset, a condition and a consequence.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequence holds in the same cycle as the condition.
`define SBDA_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequence holds in the cycle after the condition.
`define SBDA_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SBDA_ASSERT_SAME(label, clk, rst, cond, cons)
`define SBDA_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

[design/sbda_pkg.sv]
package sbda_pkg;

   // Port and default widths
   localparam int VALUE_PORT_WIDTH    = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int CHAR_WIDTH          = 8;
   localparam int BCD_WIDTH           = 4;
   // Decimal digits of the largest magnitude at the default width
   localparam int DIGITS_DEFAULT      = 19;

   // Characters
   localparam logic [CHAR_WIDTH-1:0] DIGIT_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] MINUS_SIGN = 8'h2D;

   // Double-dabble correction: digits of five or more get three added before the shift
   localparam logic [BCD_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [BCD_WIDTH-1:0] DABBLE_BIAS  = 4'd3;
   localparam logic [BCD_WIDTH-1:0] LARGEST_DIGIT = 4'd9;

   // Commands to the shared shift unit
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_DABBLE,
      CMD_SHIFT
   } sbda_cmd_type;

endpackage

[design/sbda_dabble.sv]
module sbda_dabble #(
   parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGITS      = sbda_pkg::DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  sbda_pkg::sbda_cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0]           load_value,
   output logic [sbda_pkg::BCD_WIDTH-1:0]   top_digit
);

   localparam int BW   = sbda_pkg::BCD_WIDTH;
   localparam int BCDW = DIGITS * BW;

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [VALUE_WIDTH-1:0] bin_in;
   logic [BCDW-1:0]        bcd_ff;
   logic [BCDW-1:0]        bcd_in;
   logic [BCDW-1:0]        bcd_adj;

   // Correct every digit in parallel ahead of the shift
   always_comb begin
      logic [BW-1:0] d;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[i*BW +: BW];
         if (d >= sbda_pkg::DABBLE_LIMIT) begin
            bcd_adj[i*BW +: BW] = d + sbda_pkg::DABBLE_BIAS;
         end else begin
            bcd_adj[i*BW +: BW] = d;
         end
      end
   end

   // Hold, load, dabble one bit, or drop the top digit
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      unique case (cmd)
         sbda_pkg::CMD_HOLD: begin
         end
         sbda_pkg::CMD_LOAD: begin
            bin_in = load_value;
            bcd_in = '0;
         end
         sbda_pkg::CMD_DABBLE: begin
            bcd_in = {bcd_adj[BCDW-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         sbda_pkg::CMD_SHIFT: begin
            bcd_in = {bcd_ff[BCDW-BW-1:0], {BW{1'b0}}};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCDW-1 -: BW];

endmodule

[design/signed_binary_to_decimal_ascii_unit.sv]
// Signed binary to decimal ASCII converter.
// Input channel req_: one signed value per transaction; the low VALUE_WIDTH
// bits are used and bit VALUE_WIDTH-1 is the sign. req_stall stays high
// from acceptance until the last character of that value has been handed
// to the output register.
// Result channel rsp_: one ASCII character per transaction, most significant
// first, a leading '-' for negative values, no leading zeros; rsp_last marks
// the final character. Zero gives the single character '0'.
// Sequence: a load, a double-dabble step for each of the VALUE_WIDTH bits
// on the shared shift unit, then leading zeros dropped from the DIGITS
// decimal digit positions, a '-' for a negative value, and one character
// per remaining digit.
// A stalled receiver holds the output register and freezes the sequence;
// the next value is taken while the final character still waits.
// Reset (synchronous) returns the sequencer to idle and empties the output.
`include "signed_binary_to_decimal_ascii_unit_macros.svh"

module signed_binary_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sbda_pkg::VALUE_PORT_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sbda_pkg::CHAR_WIDTH-1:0]        rsp_character,
   output logic                                   rsp_last
);

   localparam int DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
   localparam int IW     = $clog2(VALUE_WIDTH);
   localparam int RW     = $clog2(DIGITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type                        state_ff, state_in;
   logic [IW-1:0]                    iter_ff, iter_in;
   logic [RW-1:0]                    remain_ff, remain_in;
   logic                             neg_ff, neg_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sbda_pkg::CHAR_WIDTH-1:0]  rsp_character_ff, rsp_character_in;
   logic                             rsp_last_ff, rsp_last_in;

   sbda_pkg::sbda_cmd_type           cmd;
   logic [VALUE_WIDTH-1:0]           raw;
   logic [VALUE_WIDTH-1:0]           magnitude;
   logic [sbda_pkg::BCD_WIDTH-1:0]   top_digit;
   logic                             accept;
   logic                             out_free;
   logic                             raw_neg;

   // Form the unsigned magnitude of the incoming value
   assign raw       = req_value[VALUE_WIDTH-1:0];
   assign raw_neg   = raw[VALUE_WIDTH-1];
   assign magnitude = raw_neg ? ({VALUE_WIDTH{1'b0}} - raw) : raw;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sbda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (magnitude),
      .top_digit  (top_digit)
   );

   // Sequence the conversion and character emission
   always_comb begin
      state_in         = state_ff;
      iter_in          = iter_ff;
      remain_in        = remain_ff;
      neg_in           = neg_ff;
      cmd              = sbda_pkg::CMD_HOLD;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd      = sbda_pkg::CMD_LOAD;
               neg_in   = raw_neg;
               iter_in  = IW'(VALUE_WIDTH - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd     = sbda_pkg::CMD_DABBLE;
            iter_in = iter_ff - IW'(1);
            if (iter_ff == '0) begin
               remain_in = RW'(DIGITS);
               state_in  = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Drop leading zeros, keeping at least one digit
            if (top_digit == '0 && remain_ff != RW'(1)) begin
               cmd       = sbda_pkg::CMD_SHIFT;
               remain_in = remain_ff - RW'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sbda_pkg::MINUS_SIGN;
               rsp_last_in      = 1'b0;
               state_in         = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sbda_pkg::DIGIT_ZERO
                                  + {{(sbda_pkg::CHAR_WIDTH - sbda_pkg::BCD_WIDTH){1'b0}},
                                     top_digit};
               rsp_last_in      = (remain_ff == RW'(1));
               cmd              = sbda_pkg::CMD_SHIFT;
               remain_in        = remain_ff - RW'(1);
               if (remain_ff == RW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iter_ff          <= iter_in;
      remain_ff        <= remain_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // Checks on the sequencer and the shift unit
   `SBDA_ASSERT_NEXT(a_accept_starts_conv, clock, reset, accept, state_ff == ST_CONV)
   `SBDA_ASSERT_NEXT(a_conv_ends_in_skip, clock, reset, state_ff == ST_CONV && iter_ff == '0, state_ff == ST_SKIP && remain_ff == RW'(DIGITS))
   `SBDA_ASSERT_SAME(a_digit_in_range, clock, reset, state_ff == ST_DIGITS, top_digit <= sbda_pkg::LARGEST_DIGIT && remain_ff != '0)
   `SBDA_ASSERT_SAME(a_sign_only_negative, clock, reset, state_ff == ST_SIGN, neg_ff)

endmodule
